// ===== rtl/core/srct_pkg.sv =====
// ----------------------------------------------------------------------------
// srct_pkg
// Shared types and constants of the sorted range coalescing table.
// ----------------------------------------------------------------------------
package srct_pkg;

	localparam int MAX_RANGES = 64;
	localparam int INDEX_BITS = 24;
	localparam int ADDR_W     = $clog2(MAX_RANGES);
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);

	// stream payload sizes
	localparam int CMD_W       = 1;
	localparam int STATUS_W    = 2;
	localparam int IN_BITS     = CMD_W + 2 * INDEX_BITS;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = STATUS_W + CNT_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [INDEX_BITS-1:0] start;
		logic [INDEX_BITS-1:0] len;
	} entry_t;

	// access to the entry memory: one write and one read per cycle
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

// ===== rtl/core/srct_mem.sv =====
// ----------------------------------------------------------------------------
// srct_mem
// Range entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srct_mem
	import srct_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rdata
);

	entry_t mem [MAX_RANGES];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/sorted_range_coalescing_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_range_coalescing_table_unit
// Sorted table of disjoint index ranges with merge on add, trim/split on remove.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one transaction is one command, add or remove a
//   range (start, count). Output stream (m_axis_*): one transaction per
//   command with the status and the number of ranges held afterwards.
//   Commands run one at a time. s_axis_tready is high only while the
//   sequencer is idle. Bar an add of zero length, a command binary-searches
//   the table (each step reads an entry, then compares it; up to 7 steps),
//   an add then reads its two neighbors, a decision step follows, then a
//   shift of the entries behind the change (one entry per cycle, up to
//   MAX_RANGES - 1), two entry writes and the result. The time a command
//   takes is set by the entry memory and its one read per cycle.
//   Reset empties the table (count zero); memory contents are left as they
//   are, only entries below the count are ever used.
//   The result sits in an output register; a stalled receiver does not stop
//   the next command from being taken and worked on, only its own result
//   waits until the register is free.
// ----------------------------------------------------------------------------
module sorted_range_coalescing_table_unit
	import srct_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// command: [0] command, [24:1] range_start, [48:25] range_count
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// result: [1:0] status, [8:2] entries_used
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_SRCH     = 12'b0000_0000_0010,
		S_SCMP     = 12'b0000_0000_0100,
		S_PRED_RD  = 12'b0000_0000_1000,
		S_PRED_CAP = 12'b0000_0001_0000,
		S_SUCC_RD  = 12'b0000_0010_0000,
		S_SUCC_CAP = 12'b0000_0100_0000,
		S_DECIDE   = 12'b0000_1000_0000,
		S_SHIFT    = 12'b0001_0000_0000,
		S_WR_A     = 12'b0010_0000_0000,
		S_WR_B     = 12'b0100_0000_0000,
		S_RESP     = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	// command being worked on
	logic                  cmd_q;
	logic [INDEX_BITS-1:0] s_q;
	logic [INDEX_BITS-1:0] c_q;
	logic [INDEX_BITS:0]   e_q;      // end of the command range, one bit wider

	// search window
	logic [CNT_W-1:0]      lo_q;
	logic [CNT_W-1:0]      hi_q;
	logic [CNT_W-1:0]      mid_q;
	logic [CNT_W-1:0]      mid;
	logic [ADDR_W-1:0]     at_q;

	logic [CNT_W-1:0]      cnt_q;
	status_t               status_q;

	// neighbors of an add
	logic [INDEX_BITS-1:0] ps_q;
	logic [INDEX_BITS-1:0] pl_q;
	logic [INDEX_BITS-1:0] sl_q;
	logic                  pred_q;
	logic                  succ_q;

	// entry hit by a remove
	logic [INDEX_BITS-1:0] ent_st_q;
	logic [INDEX_BITS-1:0] ent_len_q;
	logic [INDEX_BITS:0]   ent_end_q;

	// shift engine
	logic                  up_q;
	logic [CNT_W-1:0]      mv_q;
	logic [ADDR_W-1:0]     src_q;
	logic [ADDR_W-1:0]     dst_q;
	logic                  pend_q;

	// final entry writes
	logic                  has_a_q;
	logic [ADDR_W-1:0]     wa_addr_q;
	entry_t                wa_data_q;
	logic                  has_b_q;
	logic [ADDR_W-1:0]     wb_addr_q;
	entry_t                wb_data_q;

	// output register
	logic                  m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	mem_req_t              mreq;
	entry_t                rd;
	logic [INDEX_BITS:0]   rd_end;
	logic                  in_fire;

	srct_mem u_mem (
		.clk   (clk),
		.req   (mreq),
		.rdata (rd)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign mid    = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_end = {1'b0, rd.start} + {1'b0, rd.len};

	// memory port steering
	always_comb begin
		mreq = '0;
		unique case (state_q)
			S_SRCH:    mreq.raddr = mid[ADDR_W-1:0];
			S_PRED_RD: mreq.raddr = ADDR_W'(lo_q - CNT_W'(1));
			S_SUCC_RD: mreq.raddr = lo_q[ADDR_W-1:0];
			S_SHIFT: begin
				mreq.raddr = src_q;
				mreq.we    = pend_q;
				mreq.waddr = dst_q;
				mreq.wdata = rd;
			end
			S_WR_A: begin
				mreq.we    = has_a_q;
				mreq.waddr = wa_addr_q;
				mreq.wdata = wa_data_q;
			end
			S_WR_B: begin
				mreq.we    = has_b_q;
				mreq.waddr = wb_addr_q;
				mreq.wdata = wb_data_q;
			end
			default: mreq = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			// output register: loaded in the result state, freed by the receiver
			if (state_q == S_RESP && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						// an add of zero length changes nothing
						if (s_axis_tdata[0] == CMD_ADD
						    && s_axis_tdata[2*INDEX_BITS:INDEX_BITS+1] == '0) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_SCMP;
					end else if (cmd_q == CMD_ADD) begin
						state_q <= S_PRED_RD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_SCMP: begin
					if (cmd_q == CMD_REMOVE && s_q >= rd.start
					    && rd_end > {1'b0, s_q}) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_PRED_RD:  state_q <= (lo_q != '0) ? S_PRED_CAP : S_SUCC_RD;
				S_PRED_CAP: state_q <= S_SUCC_RD;
				S_SUCC_RD:  state_q <= (lo_q < cnt_q) ? S_SUCC_CAP : S_DECIDE;
				S_SUCC_CAP: state_q <= S_DECIDE;
				S_DECIDE: begin
					pend_q <= 1'b0;
					if (cmd_q == CMD_ADD) begin
						if (pred_q && succ_q) begin
							cnt_q   <= cnt_q - CNT_W'(1);
							state_q <= S_SHIFT;
						end else if (pred_q || succ_q) begin
							state_q <= S_SHIFT;
						end else if (cnt_q == CNT_W'(MAX_RANGES)) begin
							state_q <= S_RESP;
						end else begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= S_SHIFT;
						end
					end else if (c_q == '0) begin
						state_q <= S_RESP;
					end else if (s_q == ent_st_q) begin
						state_q <= S_SHIFT;
						if (e_q >= ent_end_q) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end else if (e_q < ent_end_q && cnt_q == CNT_W'(MAX_RANGES)) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_SHIFT;
						if (e_q < ent_end_q) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_SHIFT: begin
					if (mv_q != '0) begin
						pend_q <= 1'b1;
					end else begin
						// last pending write lands in this cycle
						pend_q  <= 1'b0;
						state_q <= S_WR_A;
					end
				end
				S_WR_A: state_q <= S_WR_B;
				S_WR_B: state_q <= S_RESP;
				S_RESP: begin
					if (!m_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q    <= s_axis_tdata[0];
				s_q      <= s_axis_tdata[INDEX_BITS:1];
				c_q      <= s_axis_tdata[2*INDEX_BITS:INDEX_BITS+1];
				e_q      <= {1'b0, s_axis_tdata[INDEX_BITS:1]}
				            + {1'b0, s_axis_tdata[2*INDEX_BITS:INDEX_BITS+1]};
				lo_q     <= '0;
				hi_q     <= cnt_q;
				status_q <= ST_DONE;
				has_a_q  <= 1'b0;
				has_b_q  <= 1'b0;
				mv_q     <= '0;
			end
			S_SRCH: begin
				mid_q <= mid;
				if (lo_q >= hi_q && cmd_q == CMD_REMOVE) begin
					status_q <= ST_NOTFOUND;
				end
			end
			S_SCMP: begin
				if (cmd_q == CMD_ADD) begin
					if (rd.start < s_q) begin
						lo_q <= mid_q + CNT_W'(1);
					end else begin
						hi_q <= mid_q;
					end
				end else if (s_q < rd.start) begin
					hi_q <= mid_q;
				end else if (rd_end <= {1'b0, s_q}) begin
					lo_q <= mid_q + CNT_W'(1);
				end else begin
					at_q      <= mid_q[ADDR_W-1:0];
					ent_st_q  <= rd.start;
					ent_len_q <= rd.len;
					ent_end_q <= rd_end;
				end
			end
			S_PRED_RD: pred_q <= 1'b0;
			S_PRED_CAP: begin
				ps_q   <= rd.start;
				pl_q   <= rd.len;
				pred_q <= (rd_end == {1'b0, s_q});
			end
			S_SUCC_RD: succ_q <= 1'b0;
			S_SUCC_CAP: begin
				sl_q   <= rd.len;
				succ_q <= ({1'b0, rd.start} == e_q);
			end
			S_DECIDE: begin
				if (cmd_q == CMD_ADD) begin
					if (pred_q && succ_q) begin
						has_a_q   <= 1'b1;
						wa_addr_q <= ADDR_W'(lo_q - CNT_W'(1));
						wa_data_q <= '{start: ps_q, len: pl_q + c_q + sl_q};
						up_q      <= 1'b0;
						mv_q      <= cnt_q - lo_q - CNT_W'(1);
						src_q     <= ADDR_W'(lo_q + CNT_W'(1));
					end else if (pred_q) begin
						has_a_q   <= 1'b1;
						wa_addr_q <= ADDR_W'(lo_q - CNT_W'(1));
						wa_data_q <= '{start: ps_q, len: pl_q + c_q};
					end else if (succ_q) begin
						has_a_q   <= 1'b1;
						wa_addr_q <= lo_q[ADDR_W-1:0];
						wa_data_q <= '{start: s_q, len: sl_q + c_q};
					end else if (cnt_q == CNT_W'(MAX_RANGES)) begin
						status_q <= ST_FULL;
					end else begin
						has_a_q   <= 1'b1;
						wa_addr_q <= lo_q[ADDR_W-1:0];
						wa_data_q <= '{start: s_q, len: c_q};
						up_q      <= 1'b1;
						mv_q      <= cnt_q - lo_q;
						src_q     <= ADDR_W'(cnt_q - CNT_W'(1));
					end
				end else if (c_q == '0) begin
					status_q <= ST_DONE;
				end else if (s_q == ent_st_q) begin
					if (e_q >= ent_end_q) begin
						// whole entry removed
						up_q  <= 1'b0;
						mv_q  <= cnt_q - {1'b0, at_q} - CNT_W'(1);
						src_q <= at_q + ADDR_W'(1);
					end else begin
						// head trim
						has_a_q   <= 1'b1;
						wa_addr_q <= at_q;
						wa_data_q <= '{start: ent_st_q + c_q, len: ent_len_q - c_q};
					end
				end else if (e_q >= ent_end_q) begin
					// tail trim
					has_a_q   <= 1'b1;
					wa_addr_q <= at_q;
					wa_data_q <= '{start: ent_st_q, len: s_q - ent_st_q};
				end else if (cnt_q == CNT_W'(MAX_RANGES)) begin
					status_q <= ST_FULL;
				end else begin
					// split: keep the head in place, new tail entry behind it
					has_a_q   <= 1'b1;
					wa_addr_q <= at_q;
					wa_data_q <= '{start: ent_st_q, len: s_q - ent_st_q};
					has_b_q   <= 1'b1;
					wb_addr_q <= at_q + ADDR_W'(1);
					wb_data_q <= '{start: e_q[INDEX_BITS-1:0],
					               len: INDEX_BITS'(ent_end_q - e_q)};
					up_q      <= 1'b1;
					mv_q      <= cnt_q - {1'b0, at_q} - CNT_W'(1);
					src_q     <= ADDR_W'(cnt_q - CNT_W'(1));
				end
			end
			S_SHIFT: begin
				if (mv_q != '0) begin
					mv_q  <= mv_q - CNT_W'(1);
					dst_q <= up_q ? src_q + ADDR_W'(1) : src_q - ADDR_W'(1);
					src_q <= up_q ? src_q - ADDR_W'(1) : src_q + ADDR_W'(1);
				end
			end
			S_RESP: begin
				if (!m_valid_q || m_axis_tready) begin
					m_data_q <= OUT_TDATA_W'({cnt_q, status_q});
				end
			end
			default: begin
			end
		endcase
	end

endmodule
